// File: hdl/bpa_pkg.sv
package bpa_pkg;

	localparam int WORD_BITS = 32;
	localparam int BIT_W = 5;
	localparam int IDX_W = 12;
	localparam int CNT_W = 13;
	localparam logic [CNT_W-1:0] PAGE_COUNT_RST = 13'd4096;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_RANGE     = 2'd2,
		ST_NOT_ALLOC = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [IDX_W-1:0] page_index;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] alloc_page;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_CHECK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             hit;
		logic [BIT_W-1:0] pos;
	} zpos_t;

	function automatic zpos_t first_zero(input logic [WORD_BITS-1:0] w);
		zpos_t r;
		r.hit = 1'b0;
		r.pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r.hit = 1'b1;
				r.pos = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// File: hdl/bpa_ram.sv
module bpa_ram import bpa_pkg::*; #(
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/bpa_scan.sv
module bpa_scan import bpa_pkg::*; #(
	parameter int NUM_WORDS = 128,
	localparam int WA = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
	localparam int GROUPS = (NUM_WORDS + WORD_BITS - 1) / WORD_BITS,
	localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [GW-1:0] grp,
	input  logic          upd_en,
	input  logic [WA-1:0] upd_addr,
	input  logic          upd_full,
	output logic          hit,
	output logic [WA-1:0] word
);

	// One flag per bitmap word, set while every page of that word is in use.
	logic [NUM_WORDS-1:0]        full_q;
	logic [GROUPS*WORD_BITS-1:0] padded;
	zpos_t                       zp;
	logic [GW+BIT_W-1:0]         widx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (upd_en) begin
			full_q[upd_addr] <= upd_full;
		end
	end

	always_comb begin
		padded = '1;
		padded[NUM_WORDS-1:0] = full_q;
	end

	assign zp = first_zero(padded[grp*WORD_BITS +: WORD_BITS]);
	assign widx = {grp, zp.pos};
	assign hit = zp.hit;
	assign word = widx[WA-1:0];

endmodule

// File: hdl/bitmap_page_allocator.sv
// First-fit page allocator over a bitmap of in-use marks held in a one-port-per-direction
// RAM of 32-bit words, with a per-word full flag kept in flops. An allocate scans the full
// flags 32 words per cycle, reads the first word that has a free page, and writes it back
// with the lowest free bit set; the scan runs over the 32-word groups in order, of which
// there are ceil(MAX_PAGES/1024) (4 for the default size), and the answer is full when no
// free page lies below the page limit. A free reads the addressed word and clears the bit
// (not allocated if it was already clear), or answers out of range without a read.
// One request is in flight at a time; the next request is taken while a finished response
// still waits in the output register. After reset the bitmap RAM is cleared one word per
// cycle; requests stall during that pass, while page_count writes are accepted at any time.
module bitmap_page_allocator import bpa_pkg::*; #(
	parameter int MAX_PAGES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	localparam int NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WA = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int GROUPS = (NUM_WORDS + WORD_BITS - 1) / WORD_BITS;
	localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int PGW = WA + BIT_W;
	localparam int CW = ((PGW > CNT_W) ? PGW : CNT_W) + 1;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     page_count_q;
	logic [WA-1:0]        clr_q;
	logic [GW-1:0]        grp_q;
	logic [WA-1:0]        word_q;
	logic [BIT_W-1:0]     bit_q;
	rsp_t                 res_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic [CW-1:0]        limit;
	logic [CW-1:0]        pc_ext;
	logic [CW-1:0]        idx_ext;
	logic [WA-1:0]        idx_word;
	logic                 req_acc;
	logic                 idx_range;
	logic                 out_free;
	logic                 clr_last;
	logic                 grp_last;

	logic                 scan_hit;
	logic [WA-1:0]        scan_word;

	logic                 ram_we;
	logic [WA-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [WA-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;
	logic                 sum_full;

	zpos_t                pick;
	logic [CW-1:0]        pick_page;
	logic                 pick_over;
	logic [WORD_BITS-1:0] set_word;
	logic [WORD_BITS-1:0] clr_word;
	logic                 bit_used;

	assign pc_ext = CW'(page_count_q);
	assign limit = (pc_ext > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : pc_ext;
	assign idx_ext = CW'(req.page_index);
	assign idx_word = idx_ext[WA+BIT_W-1:BIT_W];
	assign idx_range = idx_ext >= limit;
	assign req_acc = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign clr_last = clr_q == WA'(NUM_WORDS - 1);
	assign grp_last = grp_q == GW'(GROUPS - 1);

	assign pick = first_zero(ram_rdata);
	assign pick_page = CW'({word_q, pick.pos});
	assign pick_over = !pick.hit || (pick_page >= limit);
	assign set_word = ram_rdata | (WORD_BITS'(1) << pick.pos);
	assign clr_word = ram_rdata & ~(WORD_BITS'(1) << bit_q);
	assign bit_used = ram_rdata[bit_q];

	bpa_scan #(
		.NUM_WORDS(NUM_WORDS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.grp     (grp_q),
		.upd_en  (ram_we),
		.upd_addr(ram_waddr),
		.upd_full(sum_full),
		.hit     (scan_hit),
		.word    (scan_word)
	);

	bpa_ram #(
		.DEPTH(NUM_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_acc) begin
					if (req.cmd == CMD_ALLOC) begin
						state_d = S_SCAN;
					end else if (idx_range) begin
						state_d = S_DONE;
					end else begin
						state_d = S_CHECK;
					end
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					state_d = S_PICK;
				end else if (grp_last) begin
					state_d = S_DONE;
				end
			end
			S_PICK: state_d = S_DONE;
			S_CHECK: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		req_stall = state_q != S_IDLE;
		ram_re = 1'b0;
		ram_raddr = scan_word;
		ram_we = 1'b0;
		ram_waddr = word_q;
		ram_wdata = clr_word;
		sum_full = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				ram_re = req_valid && req.cmd == CMD_FREE && !idx_range;
				ram_raddr = idx_word;
			end
			S_SCAN: begin
				ram_re = scan_hit;
			end
			S_PICK: begin
				ram_we = !pick_over;
				ram_wdata = set_word;
				sum_full = &set_word;
			end
			S_CHECK: begin
				ram_we = bit_used;
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			page_count_q <= PAGE_COUNT_RST;
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				page_count_q <= cfg_data;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + WA'(1);
			end
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				grp_q <= '0;
				word_q <= idx_word;
				bit_q <= req.page_index[BIT_W-1:0];
				res_q.status <= ST_RANGE;
				res_q.alloc_page <= '0;
			end
			S_SCAN: begin
				grp_q <= grp_q + GW'(1);
				word_q <= scan_word;
				res_q.status <= ST_FULL;
				res_q.alloc_page <= '0;
			end
			S_PICK: begin
				if (!pick_over) begin
					res_q.status <= ST_OK;
					res_q.alloc_page <= pick_page[IDX_W-1:0];
				end
			end
			S_CHECK: begin
				res_q.status <= bit_used ? ST_OK : ST_NOT_ALLOC;
			end
			S_DONE: begin
				if (out_free) begin
					rsp_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// File: hdl/bpa_check.sv
module bpa_check import bpa_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input rsp_t             rsp
);

	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (!req_acc && rsp_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.alloc_page == '0)
		else $error("failed request carries a page index");

	a_rsp_owed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without a pending request");

	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |-> pend_q < 2'd2)
		else $error("request taken with two requests outstanding");

endmodule

bind bitmap_page_allocator bpa_check u_check (.*);
